FILE: hdl/trail_arrive_steering_force_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trail arrive steering force block
// Shared helpers that wrap the clocking, the reset and the error report.
// ----------------------------------------------------------------------------
`ifndef TRAIL_ARRIVE_STEERING_FORCE_MACROS_SVH
`define TRAIL_ARRIVE_STEERING_FORCE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define TASF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication with a fixed delay, disabled while reset is active.
`define TASF_ASSERT_DELAY(lbl, clk, rst_n, ante, lat, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error("delayed check failed");

`endif

FILE: hdl/tasf_pkg.sv
// ----------------------------------------------------------------------------
// Trail arrive steering force package
// Transaction types, register codes, datapath widths and chain lengths.
// ----------------------------------------------------------------------------
package tasf_pkg;

    // Input and result transactions.
    typedef struct packed {
        logic               target_present;
        logic signed [31:0] agent_x;
        logic signed [31:0] agent_y;
        logic signed [31:0] agent_vx;
        logic signed [31:0] agent_vy;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_vx;
        logic signed [31:0] target_vy;
    } t_in_item;

    typedef struct packed {
        logic               success;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } t_out_item;

    // Configuration registers.
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRAIL_DISTANCE = 2'd0,
        CFG_SLOW_RADIUS    = 2'd1,
        CFG_MAX_SPEED      = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] TRAIL_RST = 31'd0;
    localparam logic [CFG_W-1:0] SLOW_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] SPEED_RST = 31'd65536;

    // Square root cell widths: 64-bit radicand, 32-bit root.
    localparam int SQ_IN_W  = 64;
    localparam int SQ_OUT_W = 32;
    localparam int SQ_REM_W = SQ_OUT_W + 4;

    // Width of a position difference.
    localparam int DIFF_W = 34;

    // Number of cells in each chain.
    localparam int SQ_STEPS  = SQ_OUT_W;
    localparam int OFF_STEPS = 31;
    localparam int SPD_STEPS = 31;
    localparam int DES_STEPS = 32;

    // Accept to result strobe, in clock cycles.
    localparam int LATENCY = 3 + SQ_STEPS + 1 + OFF_STEPS + 3 + SQ_STEPS + 1
                           + SPD_STEPS + 1 + DES_STEPS + 1;

    // Sideband carried beside the trail offset division.
    typedef struct packed {
        logic               present;
        logic               neg_x;
        logic               neg_y;
        logic               tmag_zero;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
    } t_sb_off;

    // Sideband carried beside the distance square root.
    typedef struct packed {
        logic                     present;
        logic                     far;
        logic signed [31:0]       avx;
        logic signed [31:0]       avy;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_sb_dist;

    // Sideband carried beside the speed division.
    typedef struct packed {
        logic                     present;
        logic                     in_slow;
        logic signed [31:0]       avx;
        logic signed [31:0]       avy;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0]        dist_mag;
    } t_sb_spd;

    // Sideband carried beside the desired velocity division.
    typedef struct packed {
        logic               present;
        logic               dzero;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
    } t_sb_des;

endpackage

FILE: hdl/trail_arrive_steering_force.sv
// ----------------------------------------------------------------------------
// Trail arrive steering force
// Pipelined steering toward a point trailing the target, with arrive slowdown.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle and never raises busy.
// Each result appears on o_result for one cycle with o_done, in order;
// results cannot be held off, so the receiver must take every strobe. The
// pipeline holds the two 32-cell square root chains and the 31-, 31- and
// 32-cell divider chains, one bit per cell, plus ten stages of multiply,
// add and saturate. Configuration writes take effect at once and must only
// be made with the pipeline empty.
module trail_arrive_steering_force (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  tasf_pkg::t_in_item                   i_item,
    output logic                                 o_done,
    output tasf_pkg::t_out_item                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [tasf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tasf_pkg::CFG_W-1:0]           i_cfg_data
);
    import tasf_pkg::*;

    localparam int SB_IN_W  = $bits(t_in_item);
    localparam int SB_OFF_W = $bits(t_sb_off);
    localparam int SB_DST_W = $bits(t_sb_dist);
    localparam int SB_SPD_W = $bits(t_sb_spd);
    localparam int SB_DES_W = $bits(t_sb_des);

    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [DIFF_W-1:0] mag34(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [34:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[31:0];
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_td;
    logic [CFG_W-1:0] r_sr;
    logic [CFG_W-1:0] r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_td <= TRAIL_RST;
            r_sr <= SLOW_RST;
            r_ms <= SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRAIL_DISTANCE: r_td <= i_cfg_data;
                CFG_SLOW_RADIUS:    r_sr <= i_cfg_data;
                CFG_MAX_SPEED:      r_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline accepts in every cycle.
    assign busy = 1'b0;

    // Stage A: capture the input transaction.
    logic     r_a_vld;
    t_in_item r_a_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= i_item;
    end

    // Stage B: squares of the target velocity components.
    logic        r_b_vld;
    t_in_item    r_b_item;
    logic [63:0] r_b_sqx;
    logic [63:0] r_b_sqy;
    logic [31:0] n_b_mx;
    logic [31:0] n_b_my;

    assign n_b_mx = mag32(r_a_item.target_vx);
    assign n_b_my = mag32(r_a_item.target_vy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_item <= r_a_item;
        r_b_sqx  <= n_b_mx * n_b_mx;
        r_b_sqy  <= n_b_my * n_b_my;
    end

    // Stage C: sum of squares feeds the speed square root chain.
    logic        r_c_vld;
    t_in_item    r_c_item;
    logic [63:0] r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_item <= r_b_item;
        r_c_sum  <= r_b_sqx + r_b_sqy;
    end

    // Target speed: square root chain.
    logic                w_s1_vld  [0:SQ_STEPS];
    logic [SQ_IN_W-1:0]  w_s1_rad  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] w_s1_rem  [0:SQ_STEPS];
    logic [SQ_OUT_W-1:0] w_s1_root [0:SQ_STEPS];
    logic [SB_IN_W-1:0]  w_s1_sb   [0:SQ_STEPS];

    assign w_s1_vld[0]  = r_c_vld;
    assign w_s1_rad[0]  = r_c_sum;
    assign w_s1_rem[0]  = '0;
    assign w_s1_root[0] = '0;
    assign w_s1_sb[0]   = r_c_item;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq1
        tasf_sqrt_cell #(
            .SB_W(SB_IN_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_s1_vld[k]),
            .i_rad  (w_s1_rad[k]),
            .i_rem  (w_s1_rem[k]),
            .i_root (w_s1_root[k]),
            .i_sb   (w_s1_sb[k]),
            .o_valid(w_s1_vld[k+1]),
            .o_rad  (w_s1_rad[k+1]),
            .o_rem  (w_s1_rem[k+1]),
            .o_root (w_s1_root[k+1]),
            .o_sb   (w_s1_sb[k+1])
        );
    end

    // Stage D: trail offset numerators.
    t_in_item    n_d_item;
    logic [31:0] n_d_tmag;
    logic        r_d_vld;
    logic [31:0] r_d_den;
    logic [62:0] r_d_numx;
    logic [62:0] r_d_numy;
    t_sb_off     r_d_sb;
    logic [62:0] n_d_numx;
    logic [62:0] n_d_numy;

    assign n_d_item = t_in_item'(w_s1_sb[SQ_STEPS]);
    assign n_d_tmag = w_s1_root[SQ_STEPS];
    assign n_d_numx = mag32(n_d_item.target_vx) * r_td;
    assign n_d_numy = mag32(n_d_item.target_vy) * r_td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= w_s1_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_den          <= n_d_tmag;
        r_d_numx         <= n_d_numx;
        r_d_numy         <= n_d_numy;
        r_d_sb.present   <= n_d_item.target_present;
        r_d_sb.neg_x     <= !n_d_item.target_vx[31];
        r_d_sb.neg_y     <= !n_d_item.target_vy[31];
        r_d_sb.tmag_zero <= (n_d_tmag == '0);
        r_d_sb.ax        <= n_d_item.agent_x;
        r_d_sb.ay        <= n_d_item.agent_y;
        r_d_sb.tx        <= n_d_item.target_x;
        r_d_sb.ty        <= n_d_item.target_y;
        r_d_sb.avx       <= n_d_item.agent_vx;
        r_d_sb.avy       <= n_d_item.agent_vy;
    end

    // Trail offset: divider chain over both components.
    logic                        w_o_vld [0:OFF_STEPS];
    logic [31:0]                 w_o_den [0:OFF_STEPS];
    logic [1:0][31:0]            w_o_rem [0:OFF_STEPS];
    logic [1:0][OFF_STEPS-1:0]   w_o_quo [0:OFF_STEPS];
    logic [SB_OFF_W-1:0]         w_o_sb  [0:OFF_STEPS];

    assign w_o_vld[0] = r_d_vld;
    assign w_o_den[0] = r_d_den;
    assign w_o_rem[0] = {r_d_numy[62:OFF_STEPS], r_d_numx[62:OFF_STEPS]};
    assign w_o_quo[0] = {r_d_numy[OFF_STEPS-1:0], r_d_numx[OFF_STEPS-1:0]};
    assign w_o_sb[0]  = r_d_sb;

    for (genvar k = 0; k < OFF_STEPS; k++) begin : g_off
        tasf_div_cell #(
            .DW   (32),
            .QW   (OFF_STEPS),
            .LANES(2),
            .SB_W (SB_OFF_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_o_vld[k]),
            .i_den  (w_o_den[k]),
            .i_rem  (w_o_rem[k]),
            .i_quo  (w_o_quo[k]),
            .i_sb   (w_o_sb[k]),
            .o_valid(w_o_vld[k+1]),
            .o_den  (w_o_den[k+1]),
            .o_rem  (w_o_rem[k+1]),
            .o_quo  (w_o_quo[k+1]),
            .o_sb   (w_o_sb[k+1])
        );
    end

    // Stage E: difference from agent to trail point.
    t_sb_off                  n_e_sb;
    logic signed [DIFF_W-1:0] n_e_offx;
    logic signed [DIFF_W-1:0] n_e_offy;
    logic signed [DIFF_W-1:0] n_e_qx;
    logic signed [DIFF_W-1:0] n_e_qy;
    logic                     r_e_vld;
    logic                     r_e_present;
    logic signed [31:0]       r_e_avx;
    logic signed [31:0]       r_e_avy;
    logic signed [DIFF_W-1:0] r_e_dx;
    logic signed [DIFF_W-1:0] r_e_dy;

    assign n_e_sb   = t_sb_off'(w_o_sb[OFF_STEPS]);
    assign n_e_qx   = $signed({3'b000, w_o_quo[OFF_STEPS][0]});
    assign n_e_qy   = $signed({3'b000, w_o_quo[OFF_STEPS][1]});
    assign n_e_offx = n_e_sb.tmag_zero ? '0 : (n_e_sb.neg_x ? -n_e_qx : n_e_qx);
    assign n_e_offy = n_e_sb.tmag_zero ? '0 : (n_e_sb.neg_y ? -n_e_qy : n_e_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= w_o_vld[OFF_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_present <= n_e_sb.present;
        r_e_avx     <= n_e_sb.avx;
        r_e_avy     <= n_e_sb.avy;
        r_e_dx      <= DIFF_W'(n_e_sb.tx) + n_e_offx - DIFF_W'(n_e_sb.ax);
        r_e_dy      <= DIFF_W'(n_e_sb.ty) + n_e_offy - DIFF_W'(n_e_sb.ay);
    end

    // Stage F: squares of the difference, pre-shifted when it is large.
    logic [DIFF_W-1:0] n_f_mx;
    logic [DIFF_W-1:0] n_f_my;
    logic              n_f_large;
    logic [31:0]       n_f_sx;
    logic [31:0]       n_f_sy;
    logic              r_f_vld;
    logic [63:0]       r_f_sqx;
    logic [63:0]       r_f_sqy;
    t_sb_dist          r_f_sb;

    assign n_f_mx    = mag34(r_e_dx);
    assign n_f_my    = mag34(r_e_dy);
    assign n_f_large = (|n_f_mx[DIFF_W-1:31]) || (|n_f_my[DIFF_W-1:31]);
    assign n_f_sx    = n_f_large ? n_f_mx[33:2] : n_f_mx[31:0];
    assign n_f_sy    = n_f_large ? n_f_my[33:2] : n_f_my[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_sqx        <= n_f_sx * n_f_sx;
        r_f_sqy        <= n_f_sy * n_f_sy;
        r_f_sb.present <= r_e_present;
        r_f_sb.far     <= n_f_large;
        r_f_sb.avx     <= r_e_avx;
        r_f_sb.avy     <= r_e_avy;
        r_f_sb.dx      <= r_e_dx;
        r_f_sb.dy      <= r_e_dy;
    end

    // Stage G: sum of squares feeds the distance square root chain.
    logic        r_g_vld;
    logic [63:0] r_g_sum;
    t_sb_dist    r_g_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_sum <= r_f_sqx + r_f_sqy;
        r_g_sb  <= r_f_sb;
    end

    logic                w_s2_vld  [0:SQ_STEPS];
    logic [SQ_IN_W-1:0]  w_s2_rad  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] w_s2_rem  [0:SQ_STEPS];
    logic [SQ_OUT_W-1:0] w_s2_root [0:SQ_STEPS];
    logic [SB_DST_W-1:0] w_s2_sb   [0:SQ_STEPS];

    assign w_s2_vld[0]  = r_g_vld;
    assign w_s2_rad[0]  = r_g_sum;
    assign w_s2_rem[0]  = '0;
    assign w_s2_root[0] = '0;
    assign w_s2_sb[0]   = r_g_sb;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq2
        tasf_sqrt_cell #(
            .SB_W(SB_DST_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_s2_vld[k]),
            .i_rad  (w_s2_rad[k]),
            .i_rem  (w_s2_rem[k]),
            .i_root (w_s2_root[k]),
            .i_sb   (w_s2_sb[k]),
            .o_valid(w_s2_vld[k+1]),
            .o_rad  (w_s2_rad[k+1]),
            .o_rem  (w_s2_rem[k+1]),
            .o_root (w_s2_root[k+1]),
            .o_sb   (w_s2_sb[k+1])
        );
    end

    // Stage H: distance, slowing test and the speed numerator.
    t_sb_dist          n_h_sb;
    logic [DIFF_W-1:0] n_h_dist;
    logic              n_h_inside;
    logic [61:0]       n_h_num;
    logic              r_h_vld;
    logic [61:0]       r_h_num;
    logic [CFG_W-1:0]  r_h_den;
    t_sb_spd           r_h_sb;

    assign n_h_sb     = t_sb_dist'(w_s2_sb[SQ_STEPS]);
    assign n_h_dist   = n_h_sb.far ? {w_s2_root[SQ_STEPS], 2'b00}
                                   : {2'b00, w_s2_root[SQ_STEPS]};
    assign n_h_inside = (n_h_dist < {{(DIFF_W-CFG_W){1'b0}}, r_sr});
    assign n_h_num    = n_h_inside ? r_ms * n_h_dist[CFG_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= w_s2_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_num         <= n_h_num;
        r_h_den         <= r_sr;
        r_h_sb.present  <= n_h_sb.present;
        r_h_sb.in_slow  <= n_h_inside;
        r_h_sb.avx      <= n_h_sb.avx;
        r_h_sb.avy      <= n_h_sb.avy;
        r_h_sb.dx       <= n_h_sb.dx;
        r_h_sb.dy       <= n_h_sb.dy;
        r_h_sb.dist_mag <= n_h_dist;
    end

    // Arrive speed: divider chain.
    logic                          w_p_vld [0:SPD_STEPS];
    logic [CFG_W-1:0]              w_p_den [0:SPD_STEPS];
    logic [0:0][CFG_W-1:0]         w_p_rem [0:SPD_STEPS];
    logic [0:0][SPD_STEPS-1:0]     w_p_quo [0:SPD_STEPS];
    logic [SB_SPD_W-1:0]           w_p_sb  [0:SPD_STEPS];

    assign w_p_vld[0] = r_h_vld;
    assign w_p_den[0] = r_h_den;
    assign w_p_rem[0] = r_h_num[61:SPD_STEPS];
    assign w_p_quo[0] = r_h_num[SPD_STEPS-1:0];
    assign w_p_sb[0]  = r_h_sb;

    for (genvar k = 0; k < SPD_STEPS; k++) begin : g_spd
        tasf_div_cell #(
            .DW   (CFG_W),
            .QW   (SPD_STEPS),
            .LANES(1),
            .SB_W (SB_SPD_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_p_vld[k]),
            .i_den  (w_p_den[k]),
            .i_rem  (w_p_rem[k]),
            .i_quo  (w_p_quo[k]),
            .i_sb   (w_p_sb[k]),
            .o_valid(w_p_vld[k+1]),
            .o_den  (w_p_den[k+1]),
            .o_rem  (w_p_rem[k+1]),
            .o_quo  (w_p_quo[k+1]),
            .o_sb   (w_p_sb[k+1])
        );
    end

    // Stage I: desired velocity numerators.
    t_sb_spd          n_i_sb;
    logic [CFG_W-1:0] n_i_speed;
    logic [64:0]      n_i_prodx;
    logic [64:0]      n_i_prody;
    logic             r_i_vld;
    logic [DIFF_W-1:0] r_i_den;
    logic [65:0]      r_i_numx;
    logic [65:0]      r_i_numy;
    t_sb_des          r_i_sb;

    assign n_i_sb    = t_sb_spd'(w_p_sb[SPD_STEPS]);
    assign n_i_speed = n_i_sb.in_slow ? w_p_quo[SPD_STEPS][0] : r_ms;
    assign n_i_prodx = mag34(n_i_sb.dx) * n_i_speed;
    assign n_i_prody = mag34(n_i_sb.dy) * n_i_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= w_p_vld[SPD_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_den        <= n_i_sb.dist_mag;
        r_i_numx       <= {1'b0, n_i_prodx};
        r_i_numy       <= {1'b0, n_i_prody};
        r_i_sb.present <= n_i_sb.present;
        r_i_sb.dzero   <= (n_i_sb.dist_mag == '0);
        r_i_sb.neg_x   <= n_i_sb.dx[DIFF_W-1];
        r_i_sb.neg_y   <= n_i_sb.dy[DIFF_W-1];
        r_i_sb.avx     <= n_i_sb.avx;
        r_i_sb.avy     <= n_i_sb.avy;
    end

    // Desired velocity: divider chain over both components.
    logic                        w_q_vld [0:DES_STEPS];
    logic [DIFF_W-1:0]           w_q_den [0:DES_STEPS];
    logic [1:0][DIFF_W-1:0]      w_q_rem [0:DES_STEPS];
    logic [1:0][DES_STEPS-1:0]   w_q_quo [0:DES_STEPS];
    logic [SB_DES_W-1:0]         w_q_sb  [0:DES_STEPS];

    assign w_q_vld[0] = r_i_vld;
    assign w_q_den[0] = r_i_den;
    assign w_q_rem[0] = {r_i_numy[65:DES_STEPS], r_i_numx[65:DES_STEPS]};
    assign w_q_quo[0] = {r_i_numy[DES_STEPS-1:0], r_i_numx[DES_STEPS-1:0]};
    assign w_q_sb[0]  = r_i_sb;

    for (genvar k = 0; k < DES_STEPS; k++) begin : g_des
        tasf_div_cell #(
            .DW   (DIFF_W),
            .QW   (DES_STEPS),
            .LANES(2),
            .SB_W (SB_DES_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_q_vld[k]),
            .i_den  (w_q_den[k]),
            .i_rem  (w_q_rem[k]),
            .i_quo  (w_q_quo[k]),
            .i_sb   (w_q_sb[k]),
            .o_valid(w_q_vld[k+1]),
            .o_den  (w_q_den[k+1]),
            .o_rem  (w_q_rem[k+1]),
            .o_quo  (w_q_quo[k+1]),
            .o_sb   (w_q_sb[k+1])
        );
    end

    // Stage J: steering force, saturated, into the result register.
    t_sb_des            n_j_sb;
    logic signed [34:0] n_j_qx;
    logic signed [34:0] n_j_qy;
    logic signed [34:0] n_j_desx;
    logic signed [34:0] n_j_desy;
    logic               r_done;
    t_out_item          r_result;

    assign n_j_sb   = t_sb_des'(w_q_sb[DES_STEPS]);
    assign n_j_qx   = $signed({3'b000, w_q_quo[DES_STEPS][0]});
    assign n_j_qy   = $signed({3'b000, w_q_quo[DES_STEPS][1]});
    assign n_j_desx = n_j_sb.dzero ? '0 : (n_j_sb.neg_x ? -n_j_qx : n_j_qx);
    assign n_j_desy = n_j_sb.dzero ? '0 : (n_j_sb.neg_y ? -n_j_qy : n_j_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_q_vld[DES_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.success <= n_j_sb.present;
        r_result.force_x <= n_j_sb.present ? sat32(n_j_desx - 35'(n_j_sb.avx)) : '0;
        r_result.force_y <= n_j_sb.present ? sat32(n_j_desy - 35'(n_j_sb.avy)) : '0;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/tasf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root; hands its state onward.
// ----------------------------------------------------------------------------
module tasf_sqrt_cell #(
    parameter int SB_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tasf_pkg::SQ_IN_W-1:0]  i_rad,
    input  logic [tasf_pkg::SQ_REM_W-1:0] i_rem,
    input  logic [tasf_pkg::SQ_OUT_W-1:0] i_root,
    input  logic [SB_W-1:0]               i_sb,
    output logic                          o_valid,
    output logic [tasf_pkg::SQ_IN_W-1:0]  o_rad,
    output logic [tasf_pkg::SQ_REM_W-1:0] o_rem,
    output logic [tasf_pkg::SQ_OUT_W-1:0] o_root,
    output logic [SB_W-1:0]               o_sb
);
    import tasf_pkg::*;

    logic                r_valid;
    logic [SQ_IN_W-1:0]  r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [SB_W-1:0]     r_sb;

    logic [SQ_REM_W-1:0] n_acc;
    logic [SQ_REM_W-1:0] n_trial;
    logic [SQ_REM_W-1:0] n_diff;
    logic                n_ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign n_acc   = {i_rem[SQ_REM_W-3:0], i_rad[SQ_IN_W-1 -: 2]};
    assign n_trial = {{(SQ_REM_W-SQ_OUT_W-2){1'b0}}, i_root, 2'b01};
    assign n_ge    = (n_acc >= n_trial);
    assign n_diff  = n_acc - n_trial;

    // Valid travels with reset; the payload does not need it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= {i_rad[SQ_IN_W-3:0], 2'b00};
        r_rem  <= n_ge ? n_diff : n_acc;
        r_root <= {i_root[SQ_OUT_W-2:0], n_ge};
        r_sb   <= i_sb;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_sb    = r_sb;

endmodule

FILE: hdl/tasf_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division for each lane, shared divisor.
// ----------------------------------------------------------------------------
module tasf_div_cell #(
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int LANES = 2,
    parameter int SB_W  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [DW-1:0]              i_den,
    input  logic [LANES-1:0][DW-1:0]   i_rem,
    input  logic [LANES-1:0][QW-1:0]   i_quo,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_valid,
    output logic [DW-1:0]              o_den,
    output logic [LANES-1:0][DW-1:0]   o_rem,
    output logic [LANES-1:0][QW-1:0]   o_quo,
    output logic [SB_W-1:0]            o_sb
);
    import tasf_pkg::*;

    logic                     r_valid;
    logic [DW-1:0]            r_den;
    logic [LANES-1:0][DW-1:0] r_rem;
    logic [LANES-1:0][QW-1:0] r_quo;
    logic [SB_W-1:0]          r_sb;

    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] n_quo;

    // The quotient register holds the unused low numerator bits on top and
    // collects quotient bits from the bottom.
    always_comb begin
        logic [DW:0] acc;
        logic [DW:0] diff;
        logic        ge;
        for (int l = 0; l < LANES; l++) begin
            acc      = {i_rem[l], i_quo[l][QW-1]};
            diff     = acc - {1'b0, i_den};
            ge       = (acc >= {1'b0, i_den});
            n_rem[l] = ge ? diff[DW-1:0] : acc[DW-1:0];
            n_quo[l] = {i_quo[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_sb  <= i_sb;
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_sb    = r_sb;

endmodule

FILE: hdl/tasf_checker.sv
// ----------------------------------------------------------------------------
// Trail arrive steering force checker
// Port-level checks on latency, ordering and the no-target result.
// ----------------------------------------------------------------------------
`include "trail_arrive_steering_force_macros.svh"

module tasf_port_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input tasf_pkg::t_in_item  i_item,
    input logic                o_done,
    input tasf_pkg::t_out_item o_result
);
    import tasf_pkg::*;

    // Every accepted transaction yields a strobe after the fixed latency.
    `TASF_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, LATENCY, o_done)

    // No strobe appears without a matching earlier accept.
    `TASF_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_done, $past(start && !busy, LATENCY))

    // The success flag follows the target flag of the same transaction.
    `TASF_ASSERT_IMPL(a_success, i_clk, i_rst_n,
        o_done && $past(start && !busy, LATENCY),
        o_result.success == $past(i_item.target_present, LATENCY))

    // Without a target the force is zero.
    `TASF_ASSERT_IMPL(a_zero_force, i_clk, i_rst_n, o_done && !o_result.success,
        (o_result.force_x == 0) && (o_result.force_y == 0))

endmodule

bind trail_arrive_steering_force tasf_port_sva u_tasf_port_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_done  (o_done),
    .o_result(o_result)
);

FILE: dv/tasf_checker.sv
// ----------------------------------------------------------------------------
// Steering force checker
// Watches the command and result channels of the trail arrive steering force
// block, predicts each force from the registers and the input transaction,
// and compares results in order.
// ----------------------------------------------------------------------------
module tasf_checker
    import tasf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_in_item             i_item,
    input  logic                 i_done,
    input  t_out_item            i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    longint unsigned trail_dist_q, slow_radius_q, max_speed_q;
    t_out_item       force_q[$];
    int              n_errors;
    int              n_predicted;
    int              n_seen;

    assign o_errors  = n_errors;
    assign o_pending = n_predicted - n_seen;

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Floor square root, bit by bit, on 64 bits.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Magnitude times factor over divisor, truncated, sign restored.
    function automatic longint ratio(longint num, longint unsigned mul,
                                     longint unsigned den);
        longint unsigned q;
        if (den == 0) return 0;
        q = magnitude(num) * mul / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_out_item steering_force(t_in_item it);
        t_out_item       r;
        longint          offx, offy, dx, dy, desx, desy;
        longint unsigned tmag, dist_v, speed, mx, my, tvxm, tvym;
        r = '0;
        if (!it.target_present) return r;
        tvxm = magnitude(longint'(it.target_vx));
        tvym = magnitude(longint'(it.target_vy));
        tmag = floor_sqrt(tvxm * tvxm + tvym * tvym);
        offx = ratio(-longint'(it.target_vx), trail_dist_q, tmag);
        offy = ratio(-longint'(it.target_vy), trail_dist_q, tmag);
        dx = longint'(it.target_x) + offx - longint'(it.agent_x);
        dy = longint'(it.target_y) + offy - longint'(it.agent_y);
        mx = magnitude(dx);
        my = magnitude(dy);
        // Large differences lose two bits before squaring.
        if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
            mx = mx >> 2;
            my = my >> 2;
            dist_v = floor_sqrt(mx * mx + my * my) << 2;
        end else begin
            dist_v = floor_sqrt(mx * mx + my * my);
        end
        if (dist_v < slow_radius_q) speed = max_speed_q * dist_v / slow_radius_q;
        else speed = max_speed_q;
        desx = ratio(dx, speed, dist_v);
        desy = ratio(dy, speed, dist_v);
        r.success = 1'b1;
        r.force_x = clamp32(desx - longint'(it.agent_vx));
        r.force_y = clamp32(desy - longint'(it.agent_vy));
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        n_errors++;
    endtask

    // Registers, predictions and comparison, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            trail_dist_q  = TRAIL_RST;
            slow_radius_q = SLOW_RST;
            max_speed_q   = SPEED_RST;
            force_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TRAIL_DISTANCE: trail_dist_q  = i_cfg_data;
                    CFG_SLOW_RADIUS:    slow_radius_q = i_cfg_data;
                    CFG_MAX_SPEED:      max_speed_q   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                n_seen++;
                if (force_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = force_q.pop_front();
                    if (i_result.success !== want.success)
                        report_mismatch($sformatf("success %b, expected %b",
                            i_result.success, want.success));
                    if (i_result.force_x !== want.force_x)
                        report_mismatch($sformatf("force_x %h, expected %h",
                            i_result.force_x, want.force_x));
                    if (i_result.force_y !== want.force_y)
                        report_mismatch($sformatf("force_y %h, expected %h",
                            i_result.force_y, want.force_y));
                end
            end
            if (i_start && !i_busy) begin
                force_q.push_back(steering_force(i_item));
                n_predicted++;
            end
        end
    end

    initial begin
        n_errors    = 0;
        n_predicted = 0;
        n_seen      = 0;
    end
endmodule

FILE: dv/tb_trail_arrive_steering_force.sv
// ----------------------------------------------------------------------------
// Trail arrive steering force testbench
// Drives directed and random transactions in bursts across several register
// settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_trail_arrive_steering_force;
    import tasf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 340;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 o_done;
    t_out_item            o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   n_errors;
    int                   n_pending;
    int                   burst_left;

    trail_arrive_steering_force dut (.*);

    tasf_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_item,
        .i_done(o_done), .i_result(o_result), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_errors(n_errors), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Send one transaction; bursts keep start high, gaps lower it between them.
    task automatic send(t_in_item it);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
    endtask

    // Let the pipeline drain before touching the registers.
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] trail, logic [CFG_W-1:0] radius,
                            logic [CFG_W-1:0] speed);
        drain();
        write_reg(CFG_TRAIL_DISTANCE, trail);
        write_reg(CFG_SLOW_RADIUS, radius);
        write_reg(CFG_MAX_SPEED, speed);
    endtask

    // Mostly nearby values so arrive slowdown is reached; some full range.
    function automatic logic signed [31:0] coord();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4:       return 0;
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    function automatic t_in_item rand_agent();
        t_in_item it;
        it.target_present = ($urandom_range(0, 9) != 0);
        it.agent_x   = coord();
        it.agent_y   = coord();
        it.agent_vx  = coord();
        it.agent_vy  = coord();
        it.target_x  = coord();
        it.target_y  = coord();
        it.target_vx = coord();
        it.target_vy = coord();
        // Sometimes put the agent close to the target.
        if ($urandom_range(0, 3) == 0) begin
            it.agent_x = it.target_x + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            it.agent_y = it.target_y + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        end
        return it;
    endfunction

    function automatic t_in_item make(logic p, int ax, int ay, int avx, int avy,
                                      int tx, int ty, int tvx, int tvy);
        t_in_item it;
        it = {p, ax, ay, avx, avy, tx, ty, tvx, tvy};
        return it;
    endfunction

    task automatic random_phase();
        repeat (RANDOM_PER_PHASE) send(rand_agent());
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_TRAIL_DISTANCE;
        i_cfg_data = '0;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases under reset values of the registers.
        send(make(0, 5, 6, 7, 8, 9, 10, 11, 12));
        send(make(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make(1, 0, 0, 1 << 16, -(1 << 16), 3 << 16, 4 << 16, 0, 0));
        send(make(1, 1 << 15, 0, 0, 0, 1 << 16, 0, 0, 0));
        send(make(1, 32'h8000_0000, 32'h8000_0000, 0, 0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        send(make(1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        send(make(0, -1, -1, -1, -1, -1, -1, -1, -1));
        send(make(1, -1, -1, -1, -1, -1, -1, -1, -1));
        set_regs(2 << 16, 5 << 16, 3 << 16);
        send(make(1, 0, 0, 0, 0, 10 << 16, 0, 1 << 16, 0));
        send(make(1, 8 << 16, 0, 0, 0, 10 << 16, 0, 1 << 16, 0));
        send(make(1, 9 << 16, 1 << 16, 0, 0, 10 << 16, 0, 1 << 16, 0));
        send(make(1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
        send(make(1, 32'h8000_0000, 0, 32'h8000_0000, 0,
                  32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000));
        send(make(1, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        random_phase();

        // Extremes of the register ranges, then one random setting.
        set_regs('1, '1, '1);
        random_phase();
        set_regs(0, 0, 1 << 16);
        random_phase();
        set_regs(1 << 16, 1 << 20, 0);
        random_phase();
        set_regs('1, 3 << 16, '1);
        random_phase();
        set_regs($urandom_range(0, 8 << 16), $urandom_range(1, 16 << 16),
                 $urandom_range(0, 8 << 16));
        random_phase();

        drain();
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #8ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/tasf_pkg.sv
hdl/tasf_sqrt_cell.sv
hdl/tasf_div_cell.sv
hdl/trail_arrive_steering_force.sv
hdl/tasf_checker.sv
dv/tasf_checker.sv
dv/tb_trail_arrive_steering_force.sv
